// File: rtl/vfx_pkg.sv
// Package for the varint frame encoder: constants, item types and the byte-list record.
package vfx_pkg;

  localparam int MAX_LENGTH_GROUPS = 4;
  localparam int GROUP_BITS        = 7;
  localparam int KEY_BYTES         = 8;
  localparam int KEY_POS_W         = $clog2(KEY_BYTES);
  localparam int LEN_W             = 28;
  localparam int MAX_RESULTS       = MAX_LENGTH_GROUPS + 2;
  localparam int CNT_W             = $clog2(MAX_RESULTS + 1);
  localparam int CAP_BITS          = GROUP_BITS * MAX_LENGTH_GROUPS;

  localparam logic [6:0] GROUP_MASK = 7'h7F;
  localparam logic       CONT_BIT   = 1'b1;

  // Largest length that the length groups can encode, clipped to the field width.
  localparam logic [LEN_W-1:0] LEN_CAP =
    (CAP_BITS >= LEN_W) ? {LEN_W{1'b1}} : LEN_W'((64'd1 << CAP_BITS) - 64'd1);

  localparam logic FUNC_START   = 1'b0;
  localparam logic FUNC_PAYLOAD = 1'b1;

  typedef struct packed {
    logic             func;
    logic [7:0]       header_code;
    logic [LEN_W-1:0] message_length;
    logic [7:0]       data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
  } out_item_t;

  // All bytes that one input item causes, oldest in slot 0.
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [CNT_W-1:0]            cnt;
    logic                        frame_end;
  } byte_job_t;

endpackage

// File: rtl/varint_frame_encoder_xor_obfuscate_top.sv
// Top level of the varint frame encoder with XOR payload obfuscation.
// A start item yields the header byte, a checksum byte and one to four 7-bit
// little-endian length bytes; a payload item yields one byte XORed with the
// rolling key byte, or nothing when the frame has no bytes left. Every
// accepted item is decoded combinationally into a registered list of its bytes,
// and an output register then hands those bytes out one byte per cycle while
// out_ready is high. Payload items therefore stream at one item per cycle while
// out_ready is high; a start item occupies the output until all of its three
// to six bytes are taken, and the decode register lets the next item be taken
// while that runs. Results pass the decode and then the output register. There
// is a combinational path from out_ready to in_ready through the single buffered
// stage, so a full decode register frees up in the same cycle that the output
// accepts the last byte of its current item.
module varint_frame_encoder_xor_obfuscate_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [63:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  vfx_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output vfx_pkg::out_item_t out_data
);
  import vfx_pkg::*;

  // Byte list handed from the decoder to the output stage.
  logic      job_valid;
  logic      take;
  byte_job_t job;

  // The decoder keeps the frame counters and the key; it updates the counters
  // at the moment an item is accepted so item order is preserved exactly.
  vfx_prep u_prep (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .take        (take),
    .job_valid   (job_valid),
    .job         (job)
  );

  // The output stage shifts the held list out, flagging the last byte of
  // each item and the final byte of the frame.
  vfx_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: rtl/vfx_prep.sv
// Item decoder: frame state, key register, and the registered byte list of each item.
module vfx_prep (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [63:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  vfx_pkg::in_item_t  in_data,
  input  logic               take,
  output logic               job_valid,
  output vfx_pkg::byte_job_t job
);
  import vfx_pkg::*;

  logic [63:0]          obfuscation_key;
  logic [LEN_W-1:0]     bytes_remaining;
  logic [KEY_POS_W-1:0] key_position;

  logic [LEN_W-1:0]     len_sat;
  logic [63:0]          len_ext;
  logic [CNT_W-1:0]     ng;
  logic [7:0]           check;
  logic [7:0]           grp;
  logic [7:0]           key_byte;
  logic                 produce;
  logic                 accept;
  byte_job_t            job_next;

  assign accept   = in_valid && in_ready;
  assign in_ready = !job_valid || take;
  assign produce  = (in_data.func == FUNC_START) || (bytes_remaining != '0);
  assign key_byte = obfuscation_key[8*key_position +: 8];

  always_comb begin
    len_sat = (in_data.message_length > LEN_CAP) ? LEN_CAP : in_data.message_length;
    len_ext = 64'(len_sat);
    ng      = CNT_W'(1);
    for (int i = 1; i < MAX_LENGTH_GROUPS; i++) begin
      if ((len_ext >> (GROUP_BITS * i)) != 64'd0) ng = CNT_W'(i + 1);
    end
    job_next = '0;
    check    = in_data.header_code;
    grp      = '0;
    if (in_data.func == FUNC_START) begin
      job_next.bytes[0] = in_data.header_code;
      for (int i = 0; i < MAX_LENGTH_GROUPS; i++) begin
        if (CNT_W'(i) < ng) begin
          grp = {(CNT_W'(i + 1) < ng) ? CONT_BIT : 1'b0,
                 7'(len_ext >> (GROUP_BITS * i)) & GROUP_MASK};
        end else begin
          grp = '0;
        end
        check = check ^ grp;
        job_next.bytes[i + 2] = grp;
      end
      job_next.bytes[1]  = check;
      job_next.cnt       = ng + CNT_W'(2);
      job_next.frame_end = (len_sat == '0);
    end else begin
      job_next.bytes[0]  = in_data.data_byte ^ key_byte;
      job_next.cnt       = CNT_W'(1);
      job_next.frame_end = (bytes_remaining == LEN_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      obfuscation_key <= '0;
      bytes_remaining <= '0;
      key_position    <= '0;
      job_valid       <= 1'b0;
    end else begin
      if (cfg_wr_en) obfuscation_key <= cfg_wr_data;
      if (accept) begin
        job_valid <= produce;
        if (in_data.func == FUNC_START) begin
          bytes_remaining <= len_sat;
          key_position    <= '0;
        end else if (bytes_remaining != '0) begin
          bytes_remaining <= bytes_remaining - LEN_W'(1);
          key_position    <= key_position + KEY_POS_W'(1);
        end
      end else if (take) begin
        job_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) job <= job_next;
  end

endmodule

// File: rtl/vfx_emit.sv
// Output stage: holds one byte list and hands its bytes out one byte per cycle while out_ready is high.
module vfx_emit (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  input  vfx_pkg::byte_job_t job,
  output logic               take,
  output logic               out_valid,
  input  logic               out_ready,
  output vfx_pkg::out_item_t out_data
);
  import vfx_pkg::*;

  byte_job_t cur;
  logic      last;
  logic      load_ok;

  assign last      = (cur.cnt == CNT_W'(1));
  assign load_ok   = !out_valid || (out_ready && last);
  assign take      = job_valid && load_ok;

  assign out_data.out_byte  = cur.bytes[0];
  assign out_data.run_last  = last;
  assign out_data.frame_end = last && cur.frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready && last) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= job;
    end else if (out_valid && out_ready) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) cur.bytes[i] <= cur.bytes[i + 1];
      cur.bytes[MAX_RESULTS-1] <= '0;
      cur.cnt                  <= cur.cnt - CNT_W'(1);
    end
  end

endmodule

// File: tb/sv/varint_frame_encoder_xor_obfuscate_top_tb.sv
// Self-checking testbench for the varint frame encoder with XOR payload obfuscation.
module varint_frame_encoder_xor_obfuscate_top_tb;
  import vfx_pkg::*;

  // Cycles allowed after the last expected byte for items that cause no byte
  // (dropped payload) to finish their way through the pipeline.
  localparam int DRAIN_CYCLES = 8;

  logic      clk;
  logic      rst;
  logic      cfg_wr_en;
  logic [63:0] cfg_wr_data;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // Predictor state: the key, the payload bytes left in the open frame and the
  // next key byte to use.
  logic [63:0]          obf_key = '0;
  logic [LEN_W-1:0]     open_bytes = '0;
  logic [KEY_POS_W-1:0] key_slot = '0;

  out_item_t expected_bytes[$];
  int        failures = 0;
  int        productive_items = 0;
  bit        quiet = 1'b0;

  varint_frame_encoder_xor_obfuscate_top DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs; far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Works out the bytes that one accepted item must produce and queues them.
  // A start item resets the frame (abandoning any open one) and emits header,
  // checksum and the little-endian length groups; a payload item emits one
  // byte XORed with the rolling key byte, or nothing when the frame is done.
  function automatic void predict_frame_bytes(input in_item_t it);
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] rest;
    logic [7:0]       chk;
    logic [7:0]       grp;
    logic [7:0]       groups[MAX_LENGTH_GROUPS];
    int               ng;
    out_item_t        r;
    if (it.func == FUNC_START) begin
      len = (it.message_length > LEN_CAP) ? LEN_CAP : it.message_length;
      open_bytes = len;
      key_slot = '0;
      rest = len;
      chk = it.header_code;
      ng = 0;
      do begin
        grp = {1'b0, rest[6:0] & GROUP_MASK};
        rest = rest >> GROUP_BITS;
        if (rest != 0) grp[7] = CONT_BIT;
        chk ^= grp;
        groups[ng] = grp;
        ng++;
      end while (rest != 0 && ng < MAX_LENGTH_GROUPS);
      r = '{out_byte: it.header_code, run_last: 1'b0, frame_end: 1'b0};
      expected_bytes.push_back(r);
      r = '{out_byte: chk, run_last: 1'b0, frame_end: 1'b0};
      expected_bytes.push_back(r);
      for (int i = 0; i < ng; i++) begin
        r.out_byte  = groups[i];
        r.run_last  = (i == ng - 1);
        r.frame_end = (i == ng - 1) && (open_bytes == 0);
        expected_bytes.push_back(r);
      end
      productive_items++;
    end else if (open_bytes != 0) begin
      open_bytes = open_bytes - 1'b1;
      r.out_byte  = it.data_byte ^ obf_key[key_slot*8 +: 8];
      r.run_last  = 1'b1;
      r.frame_end = (open_bytes == 0);
      key_slot = key_slot + 1'b1;
      expected_bytes.push_back(r);
      productive_items++;
    end
  endfunction

  function automatic in_item_t start_item(input logic [7:0] hdr, input logic [LEN_W-1:0] len);
    in_item_t it;
    it.func           = FUNC_START;
    it.header_code    = hdr;
    it.message_length = len;
    it.data_byte      = 8'($urandom);
    return it;
  endfunction

  function automatic in_item_t payload_item(input logic [7:0] data);
    in_item_t it;
    it.func           = FUNC_PAYLOAD;
    it.header_code    = 8'($urandom);
    it.message_length = LEN_W'($urandom);
    it.data_byte      = data;
    return it;
  endfunction

  // Sends one item. It must be called in the same time step in which the
  // previous item was accepted (or the input was lowered), so that valid is
  // either kept high with a new payload or dropped for a gap, never both.
  task automatic send_item(input in_item_t it);
    int gap;
    gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_frame_bytes(it);
  endtask

  // Lowers valid, waits for every queued byte, then lets the pipeline settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_key(input logic [63:0] k);
    drain_results();
    cfg_wr_data <= k;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    obf_key = k;
  endtask

  // Zero-length frames with extreme headers, and a payload item that must be
  // dropped because the frame is already complete.
  task automatic test_zero_length();
    send_item(start_item(8'h00, '0));
    send_item(payload_item(8'hFF));
    send_item(start_item(8'hFF, '0));
    drain_results();
  endtask

  // Lengths at each boundary of the 7-bit groups, up to the largest length.
  // Each start also abandons the frame the previous one opened.
  task automatic test_length_groups();
    send_item(start_item(8'h30, LEN_W'(127)));
    send_item(start_item(8'h31, LEN_W'(128)));
    send_item(start_item(8'h32, LEN_W'(16383)));
    send_item(start_item(8'h33, LEN_W'(16384)));
    send_item(start_item(8'h34, LEN_W'(2097151)));
    send_item(start_item(8'h35, LEN_W'(2097152)));
    send_item(start_item(8'hA5, {LEN_W{1'b1}}));
    drain_results();
  endtask

  // Key bytes cycle past the eighth byte, a new start mid-frame brings the key
  // back to byte 0, and a payload past the end of the frame is dropped.
  task automatic test_key_cycling();
    load_key(64'h0123_4567_89AB_CDEF);
    send_item(start_item(8'h10, LEN_W'(10)));
    send_item(payload_item(8'h00));
    send_item(payload_item(8'hFF));
    for (int i = 0; i < 7; i++) send_item(payload_item(8'($urandom)));
    send_item(start_item(8'h20, LEN_W'(2)));
    send_item(payload_item(8'h5A));
    send_item(payload_item(8'hA5));
    send_item(payload_item(8'h3C));
    drain_results();
  endtask

  // Mostly well-formed frames with random content; some frames are cut short
  // by the next start, some get extra payload that must be dropped, and a few
  // carry large or random lengths to exercise all length groups.
  task automatic test_random_frames(input int target);
    int            goal;
    int            roll;
    int            npay;
    logic [LEN_W-1:0] len;
    goal = productive_items + target;
    while (productive_items < goal) begin
      roll = $urandom_range(0, 9);
      if (roll <= 6) len = LEN_W'($urandom_range(0, 12));
      else if (roll == 7) len = LEN_W'($urandom);
      else if (roll == 8) len = LEN_W'((1 << (GROUP_BITS * $urandom_range(1, 3)))
                                       - $urandom_range(0, 1));
      else len = '0;
      if ($urandom_range(0, 15) == 0) send_item(payload_item(8'($urandom)));
      send_item(start_item(8'($urandom), len));
      roll = $urandom_range(0, 9);
      if (len > 12) npay = $urandom_range(0, 10);
      else if (roll <= 7) npay = len;
      else if (roll == 8) npay = $urandom_range(0, len);
      else npay = len + $urandom_range(1, 2);
      for (int i = 0; i < npay; i++) send_item(payload_item(8'($urandom)));
    end
    drain_results();
  endtask

  // Receiver: stalls in short random bursts, never during the quiet tail.
  initial begin
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      failures++;
    end
  endfunction

  // Every byte handed out is compared with the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        $error("out_byte: expected nothing, got 0x%0h", out_data.out_byte);
        failures++;
      end else begin
        want = expected_bytes.pop_front();
        check_field("out_byte", want.out_byte, out_data.out_byte);
        check_field("run_last", want.run_last, out_data.run_last);
        check_field("frame_end", want.frame_end, out_data.frame_end);
      end
    end
  end

  initial begin
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_zero_length();
    test_length_groups();
    test_key_cycling();

    load_key({$urandom, $urandom});
    test_random_frames(75);
    load_key(64'hFFFF_FFFF_FFFF_FFFF);
    test_random_frames(75);
    load_key(64'h0);
    test_random_frames(75);
    load_key({$urandom, $urandom});
    // Final stretch runs back to back on both sides.
    quiet = 1'b1;
    test_random_frames(75);

    drain_results();
    if (failures == 0 && expected_bytes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: varint_frame_encoder_xor_obfuscate_top.f
rtl/vfx_pkg.sv
rtl/vfx_prep.sv
rtl/vfx_emit.sv
rtl/varint_frame_encoder_xor_obfuscate_top.sv
tb/sv/varint_frame_encoder_xor_obfuscate_top_tb.sv
